// File: sv/lpfr_pkg.sv
// lpfr_pkg: constants and shared types for the LRU page frame replacer.
// No dependencies; used by the interfaces, the frame cell and the top level.
package lpfr_pkg;

  localparam int unsigned Frames   = 8;
  localparam int unsigned PageBits = 16;
  localparam int unsigned PageW    = 16;
  localparam int unsigned FrameW   = 3;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgW     = 4;
  localparam int unsigned IdxW     = (Frames > 1) ? $clog2(Frames) : 1;
  localparam int unsigned AgeW     = IdxW;

  localparam logic [AgeW-1:0]   MaxAge    = AgeW'(Frames - 1);
  localparam logic [CfgW-1:0]   CfgReset  = CfgW'(8);
  localparam logic [CfgW-1:0]   CfgMax    = CfgW'(Frames);
  localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};

  typedef logic [PageBits-1:0] page_t;
  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [AgeW-1:0]     age_t;

  // Lookup results rippled from cell 0 upward.
  typedef struct packed {
    logic  hit;
    idx_t  hit_idx;
    age_t  hit_age;
    logic  empty;
    idx_t  empty_idx;
    age_t  old_age;
    idx_t  old_idx;
    page_t old_page;
  } lpfr_scan_t;

  // Update broadcast to every cell.
  typedef struct packed {
    logic  en;
    logic  hit;
    idx_t  slot;
    age_t  hit_age;
    page_t page;
  } lpfr_upd_t;

endpackage

// File: sv/lpfr_if.sv
// lpfr_if: request channels of the LRU page frame replacer (input, result, config).
// Depends on lpfr_pkg for field widths.
interface lpfr_in_if;
  logic                         valid;
  logic                         ready;
  logic [lpfr_pkg::PageW-1:0]   page_number;
  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lpfr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         fault;
  logic [lpfr_pkg::FrameW-1:0]  frame_index;
  logic                         evicted_valid;
  logic [lpfr_pkg::PageW-1:0]   evicted_page;
  logic [lpfr_pkg::CountW-1:0]  fault_total;
  modport source (output valid, output fault, output frame_index, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input fault, input frame_index, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

interface lpfr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [lpfr_pkg::CfgW-1:0]    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/lpfr_cell.sv
// lpfr_cell: one page frame (page, valid, recency rank) with its lookup step.
// Depends on lpfr_pkg; chained by lru_page_frame_replacer.
module lpfr_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpfr_pkg::idx_t       idx_i,
  input  logic                 active_i,
  input  lpfr_pkg::page_t      page_i,
  input  lpfr_pkg::lpfr_scan_t scan_i,
  output lpfr_pkg::lpfr_scan_t scan_o,
  input  lpfr_pkg::lpfr_upd_t  upd_i
);

  lpfr_pkg::page_t page_q, page_d;
  logic            valid_q, valid_d;
  lpfr_pkg::age_t  age_q, age_d;

  always_comb begin
    scan_o = scan_i;
    if (!scan_i.hit && active_i && valid_q && (page_q == page_i)) begin
      scan_o.hit     = 1'b1;
      scan_o.hit_idx = idx_i;
      scan_o.hit_age = age_q;
    end
    if (!scan_i.empty && active_i && !valid_q) begin
      scan_o.empty     = 1'b1;
      scan_o.empty_idx = idx_i;
    end
    // cell 0 is the default victim when no rank exceeds zero
    if (active_i && ((age_q > scan_i.old_age) || (idx_i == '0))) begin
      scan_o.old_age  = age_q;
      scan_o.old_idx  = idx_i;
      scan_o.old_page = page_q;
    end
  end

  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    age_d   = age_q;
    if (upd_i.en && active_i) begin
      if (upd_i.slot == idx_i) begin
        age_d = '0;
        if (!upd_i.hit) begin
          page_d  = upd_i.page;
          valid_d = 1'b1;
        end
      end else if (valid_q && (!upd_i.hit || (age_q < upd_i.hit_age))
                   && (age_q < lpfr_pkg::MaxAge)) begin
        age_d = age_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= '0;
      valid_q <= 1'b0;
      age_q   <= '0;
    end else begin
      page_q  <= page_d;
      valid_q <= valid_d;
      age_q   <= age_d;
    end
  end

endmodule

// File: sv/lru_page_frame_replacer.sv
// lru_page_frame_replacer: LRU page replacement over a chain of frame cells.
// Depends on lpfr_pkg, lpfr_if and lpfr_cell.
//
// Usage:
//   in_i   carries one page_number per request.
//   out_o  returns one result per request: fault, frame_index, evicted_valid,
//          evicted_page and the saturating fault_total.
//   cfg_i  writes frames_in_use (0 acts as 1, above 8 acts as 8); always ready.
//          Write only while no request is in flight.
// Latency: the result is valid the cycle after the request is accepted.
// Throughput: one request per cycle while out_o.ready is high; lookup ripples
//   through the eight cells (first match, first empty frame, oldest rank).
// Reset: all frames empty, ranks and fault count zero, frames_in_use = 8.
// Stall: the result register holds while out_o.ready is low; in_i.ready is
//   high whenever the result register is empty or being drained.
module lru_page_frame_replacer (
  input  logic        clk_i,
  input  logic        rst_ni,
  lpfr_in_if.sink     in_i,
  lpfr_out_if.source  out_o,
  lpfr_cfg_if.sink    cfg_i
);

  logic [lpfr_pkg::CfgW-1:0]   cfg_q, n_eff;
  logic [lpfr_pkg::CountW-1:0] fault_q, fault_d;
  logic                        out_valid_q;
  logic                        fault_r_q;
  lpfr_pkg::idx_t              slot_q;
  logic                        ev_valid_q;
  lpfr_pkg::page_t             ev_page_q;

  logic [lpfr_pkg::Frames-1:0]   active;
  lpfr_pkg::lpfr_scan_t          scan [lpfr_pkg::Frames+1];
  lpfr_pkg::lpfr_upd_t           upd;
  lpfr_pkg::page_t               pg;
  logic                          accept, evict;
  lpfr_pkg::idx_t                slot;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign pg          = in_i.page_number[lpfr_pkg::PageBits-1:0];

  always_comb begin
    if (cfg_q == '0) begin
      n_eff = lpfr_pkg::CfgW'(1);
    end else if (cfg_q > lpfr_pkg::CfgMax) begin
      n_eff = lpfr_pkg::CfgMax;
    end else begin
      n_eff = cfg_q;
    end
  end

  assign scan[0] = '0;

  for (genvar i = 0; i < lpfr_pkg::Frames; i++) begin : g_cell
    assign active[i] = (n_eff > lpfr_pkg::CfgW'(i));
    lpfr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (lpfr_pkg::IdxW'(i)),
      .active_i (active[i]),
      .page_i   (pg),
      .scan_i   (scan[i]),
      .scan_o   (scan[i+1]),
      .upd_i    (upd)
    );
  end

  always_comb begin
    evict = 1'b0;
    if (scan[lpfr_pkg::Frames].hit) begin
      slot = scan[lpfr_pkg::Frames].hit_idx;
    end else if (scan[lpfr_pkg::Frames].empty) begin
      slot = scan[lpfr_pkg::Frames].empty_idx;
    end else begin
      slot  = scan[lpfr_pkg::Frames].old_idx;
      evict = 1'b1;
    end
    upd.en      = accept;
    upd.hit     = scan[lpfr_pkg::Frames].hit;
    upd.slot    = slot;
    upd.hit_age = scan[lpfr_pkg::Frames].hit_age;
    upd.page    = pg;
    fault_d     = fault_q;
    if (accept && !scan[lpfr_pkg::Frames].hit && (fault_q != lpfr_pkg::CountMax)) begin
      fault_d = fault_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= lpfr_pkg::CfgReset;
      fault_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        cfg_q <= cfg_i.data;
      end
      fault_q <= fault_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fault_r_q  <= !scan[lpfr_pkg::Frames].hit;
      slot_q     <= slot;
      ev_valid_q <= evict;
      ev_page_q  <= evict ? scan[lpfr_pkg::Frames].old_page : '0;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.fault         = fault_r_q;
  assign out_o.frame_index   = lpfr_pkg::FrameW'(slot_q);
  assign out_o.evicted_valid = ev_valid_q;
  assign out_o.evicted_page  = lpfr_pkg::PageW'(ev_page_q);
  assign out_o.fault_total   = fault_q;

endmodule

// File: sv/lpfr_checker.sv
// lpfr_checker: port-level assertions for lru_page_frame_replacer.
// Depends on lpfr_pkg; attached to the top level by the bind below.
module lpfr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic                        fault_i,
  input logic                        evicted_valid_i,
  input logic [lpfr_pkg::PageW-1:0]  evicted_page_i,
  input logic [lpfr_pkg::CountW-1:0] fault_total_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("no result the cycle after a request");

  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && evicted_valid_i |-> fault_i)
    else $error("eviction reported on a hit");

  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !evicted_valid_i |-> evicted_page_i == '0)
    else $error("evicted page nonzero without eviction");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && fault_i |-> fault_total_i != '0)
    else $error("fault with zero fault total");

endmodule

bind lru_page_frame_replacer lpfr_checker u_lpfr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .fault_i         (out_o.fault),
  .evicted_valid_i (out_o.evicted_valid),
  .evicted_page_i  (out_o.evicted_page),
  .fault_total_i   (out_o.fault_total)
);
